FILE: hw/rtl/halton_radical_inverse_assert.svh
// Assertion macros for the Halton radical inverse block.
// Used by the top level; empty when SYNTH is defined.
`ifndef HALTON_RADICAL_INVERSE_ASSERT_SVH
`define HALTON_RADICAL_INVERSE_ASSERT_SVH
`ifndef SYNTH
`define HRI_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define HRI_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HRI_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define HRI_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

FILE: hw/rtl/hri_pkg.sv
// Shared constants for the Halton radical inverse pipeline.
// No dependencies.
`default_nettype none
package hri_pkg;
  localparam int DIGIT_W = 7;
  localparam int SEL_W = 5;
  localparam int SEL_CODES = 32;
  localparam int DIM_W = 8;
  localparam int IDX_PORT_W = 32;

  // first 23 primes; codes 23..31 never selected
  localparam logic [DIGIT_W-1:0] PRIMES [SEL_CODES] = '{
    7'd2, 7'd3, 7'd5, 7'd7, 7'd11, 7'd13, 7'd17, 7'd19,
    7'd23, 7'd29, 7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53,
    7'd59, 7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83,
    7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2
  };
endpackage
`default_nettype wire

FILE: hw/rtl/hri_ifs.sv
// Valid/ready channel interfaces for the Halton radical inverse block.
// Depends on hri_pkg.
`default_nettype none
interface hri_in_if import hri_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [IDX_PORT_W-1:0] sample_index;
  logic [DIM_W-1:0]      dimension;
  modport source (output valid, output sample_index, output dimension, input ready);
  modport sink (input valid, input sample_index, input dimension, output ready);
endinterface

interface hri_out_if #(parameter int FRAC_W = 32);
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] fraction;
  modport source (output valid, output fraction, input ready);
  modport sink (input valid, input fraction, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hri_div.sv
// Two-stage divide of a W-bit value by the selected prime: reciprocal
// multiply, then one correction step. Depends on hri_pkg.
`default_nettype none
module hri_div import hri_pkg::*; #(
  parameter int W = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [W-1:0]      in_x,
  input  wire logic [SEL_W-1:0]  in_sel,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [W-1:0]           out_q,
  output logic [DIGIT_W-1:0]     out_r,
  output logic [SEL_W-1:0]       out_sel,
  output logic [SIDE_W-1:0]      out_side
);
  logic [W-1:0] recip_tab [SEL_CODES];

  for (genvar g = 0; g < SEL_CODES; g++) begin : g_recip
    localparam logic [63:0] RCP = (64'd1 << W) / PRIMES[g];
    assign recip_tab[g] = RCP[W-1:0];
  end

  logic              a_valid_r;
  logic [W-1:0]      a_x_r;
  logic [SEL_W-1:0]  a_sel_r;
  logic [SIDE_W-1:0] a_side_r;
  logic [2*W-1:0]    a_prod_r;
  logic [2*W-1:0]    a_prod_nxt;

  logic              b_valid_r;
  logic [W-1:0]      b_q_r;
  logic [DIGIT_W-1:0] b_r_r;
  logic [SEL_W-1:0]  b_sel_r;
  logic [SIDE_W-1:0] b_side_r;
  logic [W-1:0]      b_q_nxt;
  logic [DIGIT_W-1:0] b_r_nxt;

  logic [W-1:0] q0;
  logic [W-1:0] base_w;
  logic [W-1:0] rem;

  assign a_prod_nxt = {{W{1'b0}}, in_x} * {{W{1'b0}}, recip_tab[in_sel]};

  always_comb begin
    q0     = a_prod_r[2*W-1:W];
    base_w = W'(PRIMES[a_sel_r]);
    rem    = a_x_r - q0 * base_w;
    if (rem >= base_w) begin
      b_q_nxt = q0 + W'(1);
      b_r_nxt = DIGIT_W'(rem - base_w);
    end else begin
      b_q_nxt = q0;
      b_r_nxt = DIGIT_W'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= in_x;
      a_sel_r  <= in_sel;
      a_side_r <= in_side;
      a_prod_r <= a_prod_nxt;
      b_q_r    <= b_q_nxt;
      b_r_r    <= b_r_nxt;
      b_sel_r  <= a_sel_r;
      b_side_r <= a_side_r;
    end
  end

  assign out_valid = b_valid_r;
  assign out_q     = b_q_r;
  assign out_r     = b_r_r;
  assign out_sel   = b_sel_r;
  assign out_side  = b_side_r;
endmodule
`default_nettype wire

FILE: hw/rtl/halton_radical_inverse.sv
// Halton radical inverse: fraction = floor(2^FRACTION_BITS * mirrored base-b digits of
// sample_index), b = prime[dimension mod NUM_BASES]. Fully pipelined, one transaction
// per cycle unless the output stalls; the pipeline has one input stage, two
// stages per digit for digit extraction and four per digit for the exact scaled
// accumulation, each a reciprocal-multiply divider. A stall at the output holds the
// whole pipeline. Depends on hri_pkg, hri_ifs, hri_div and the assertion header.
`default_nettype none
`include "halton_radical_inverse_assert.svh"
module halton_radical_inverse import hri_pkg::*; #(
  parameter int NUM_BASES = 23,
  parameter int INDEX_BITS = 32,
  parameter int FRACTION_BITS = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  hri_in_if.sink   in_ch,
  hri_out_if.source out_ch
);
  localparam int LO_W = FRACTION_BITS / 2;
  localparam int HI_W = FRACTION_BITS - LO_W;
  localparam int W1 = HI_W + DIGIT_W;
  localparam int W2 = LO_W + DIGIT_W;
  localparam int DV_W = INDEX_BITS * DIGIT_W;
  localparam int SIDE_W = DV_W + FRACTION_BITS;

  logic en;
  logic out_valid;

  assign en = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  // dimension mod NUM_BASES
  logic [SEL_W-1:0] sel_tab [2**DIM_W];
  for (genvar g = 0; g < 2**DIM_W; g++) begin : g_sel
    localparam int MODV = g % NUM_BASES;
    assign sel_tab[g] = SEL_W'(MODV);
  end

  logic                  s0_valid_r;
  logic [INDEX_BITS-1:0] s0_idx_r;
  logic [SEL_W-1:0]      s0_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_idx_r <= in_ch.sample_index[INDEX_BITS-1:0];
      s0_sel_r <= sel_tab[in_ch.dimension];
    end
  end

  // digit extraction, least significant digit first
  logic                  ex_v    [INDEX_BITS];
  logic [INDEX_BITS-1:0] ex_q    [INDEX_BITS];
  logic [DIGIT_W-1:0]    ex_r    [INDEX_BITS];
  logic [SEL_W-1:0]      ex_sel  [INDEX_BITS];
  logic [SIDE_W-1:0]     ex_side [INDEX_BITS];
  logic [SIDE_W-1:0]     ex_ins  [INDEX_BITS];

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_ex
    logic                  v_i;
    logic [INDEX_BITS-1:0] x_i;
    logic [SEL_W-1:0]      sel_i;
    logic [SIDE_W-1:0]     side_i;
    if (k == 0) begin : g_first
      assign v_i    = s0_valid_r;
      assign x_i    = s0_idx_r;
      assign sel_i  = s0_sel_r;
      assign side_i = '0;
    end else begin : g_next
      assign v_i    = ex_v[k-1];
      assign x_i    = ex_q[k-1];
      assign sel_i  = ex_sel[k-1];
      assign side_i = ex_ins[k-1];
    end
    always_comb begin
      ex_ins[k] = ex_side[k];
      ex_ins[k][k*DIGIT_W +: DIGIT_W] = ex_r[k];
    end
    hri_div #(.W(INDEX_BITS), .SIDE_W(SIDE_W)) u_ex (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(v_i), .in_x(x_i), .in_sel(sel_i), .in_side(side_i),
      .out_valid(ex_v[k]), .out_q(ex_q[k]), .out_r(ex_r[k]),
      .out_sel(ex_sel[k]), .out_side(ex_side[k])
    );
  end

  // accumulation, most significant digit first: acc = (d*2^F + acc) / b,
  // split in a high and a low half
  logic               c1_v    [INDEX_BITS];
  logic [W1-1:0]      c1_q    [INDEX_BITS];
  logic [DIGIT_W-1:0] c1_r    [INDEX_BITS];
  logic [SEL_W-1:0]   c1_sel  [INDEX_BITS];
  logic [SIDE_W-1:0]  c1_side [INDEX_BITS];
  logic [SIDE_W-1:0]  c1_ins  [INDEX_BITS];
  logic               c2_v    [INDEX_BITS];
  logic [W2-1:0]      c2_q    [INDEX_BITS];
  logic [DIGIT_W-1:0] c2_r    [INDEX_BITS];
  logic [SEL_W-1:0]   c2_sel  [INDEX_BITS];
  logic [SIDE_W-1:0]  c2_side [INDEX_BITS];
  logic [SIDE_W-1:0]  c2_ins  [INDEX_BITS];

  for (genvar j = 0; j < INDEX_BITS; j++) begin : g_acc
    localparam int DK = INDEX_BITS - 1 - j;
    logic              v_i;
    logic [SEL_W-1:0]  sel_i;
    logic [SIDE_W-1:0] side_i;
    logic [W1-1:0]     x1;
    logic [W2-1:0]     x2;
    if (j == 0) begin : g_first
      assign v_i    = ex_v[INDEX_BITS-1];
      assign sel_i  = ex_sel[INDEX_BITS-1];
      assign side_i = ex_ins[INDEX_BITS-1];
    end else begin : g_next
      assign v_i    = c2_v[j-1];
      assign sel_i  = c2_sel[j-1];
      assign side_i = c2_ins[j-1];
    end
    assign x1 = {side_i[DK*DIGIT_W +: DIGIT_W], side_i[DV_W+LO_W +: HI_W]};
    assign x2 = {c1_r[j], c1_ins[j][DV_W +: LO_W]};
    always_comb begin
      c1_ins[j] = c1_side[j];
      c1_ins[j][DV_W+LO_W +: HI_W] = c1_q[j][HI_W-1:0];
      c2_ins[j] = c2_side[j];
      c2_ins[j][DV_W +: LO_W] = c2_q[j][LO_W-1:0];
    end
    hri_div #(.W(W1), .SIDE_W(SIDE_W)) u_hi (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(v_i), .in_x(x1), .in_sel(sel_i), .in_side(side_i),
      .out_valid(c1_v[j]), .out_q(c1_q[j]), .out_r(c1_r[j]),
      .out_sel(c1_sel[j]), .out_side(c1_side[j])
    );
    hri_div #(.W(W2), .SIDE_W(SIDE_W)) u_lo (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(c1_v[j]), .in_x(x2), .in_sel(c1_sel[j]), .in_side(c1_ins[j]),
      .out_valid(c2_v[j]), .out_q(c2_q[j]), .out_r(c2_r[j]),
      .out_sel(c2_sel[j]), .out_side(c2_side[j])
    );
  end

  assign out_valid       = c2_v[INDEX_BITS-1];
  assign out_ch.valid    = out_valid;
  assign out_ch.fraction = c2_ins[INDEX_BITS-1][DV_W +: FRACTION_BITS];

  logic last_digits_zero;
  logic last_rem_zero;
  logic zero_result;
  assign last_digits_zero = (c2_ins[INDEX_BITS-1][DV_W-1:0] == '0);
  assign last_rem_zero    = (c2_r[INDEX_BITS-1] == '0) || !out_valid;
  assign zero_result      = (out_ch.fraction == '0) && last_rem_zero;

  `HRI_ASSERT_IMPL(a_sel_range, clk, rst_n, s0_valid_r, s0_sel_r < SEL_W'(NUM_BASES))
  `HRI_ASSERT_IMPL(a_digit_range, clk, rst_n, ex_v[0], ex_r[0] < PRIMES[ex_sel[0]])
  `HRI_ASSERT_IMPL(a_zero_index, clk, rst_n, out_valid && last_digits_zero, zero_result)
endmodule
`default_nettype wire
